// ===== sv/psel_pkg.sv =====
`default_nettype none

package psel_pkg;

  // item function codes
  localparam logic FUNC_UPDATE = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  // process state codes
  localparam logic [2:0] PS_NEW     = 3'd0;
  localparam logic [2:0] PS_READY   = 3'd1;
  localparam logic [2:0] PS_RUNNING = 3'd2;
  localparam logic [2:0] PS_WAITING = 3'd3;
  localparam logic [2:0] PS_EXITING = 3'd4;

  // scheduling modes
  localparam logic [2:0] MODE_FCFS_NP = 3'd0;
  localparam logic [2:0] MODE_FCFS_P  = 3'd1;
  localparam logic [2:0] MODE_RR      = 3'd2;
  localparam logic [2:0] MODE_SJF     = 3'd3;
  localparam logic [2:0] MODE_SRTF    = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_AVAIL    = 2'd0;
  localparam logic [1:0] STAT_ALL_WAIT = 2'd1;
  localparam logic [1:0] STAT_ALL_EXIT = 2'd2;
  localparam logic [1:0] STAT_UPD_ACK  = 2'd3;

  // configuration register indexes
  localparam logic REG_SCHED_MODE = 1'b0;
  localparam logic REG_NUM_PROCS  = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EVAL,
    S_DONE
  } psel_state_t;

  // control from the sequencer to the scan unit
  typedef struct packed {
    logic clr;  // start of a new select scan
    logic dv;   // table entry data present this cycle
  } scan_ctl_t;

  // verdict of the scan unit
  typedef struct packed {
    logic [1:0] status;
    logic       found;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== sv/psel_ram.sv =====
`default_nettype none

module psel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== sv/psel_scan.sv =====
`default_nettype none

module psel_scan import psel_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire scan_ctl_t                      ctl,
  input  wire logic [$clog2(MAX_PROCS)-1:0]   idx,
  input  wire logic [2:0]                     st_data,
  input  wire logic [31:0]                    tm_data,
  input  wire logic [$clog2(MAX_PROCS)-1:0]   rr_start,
  input  wire logic [$clog2(MAX_PROCS+1)-1:0] n_used,
  input  wire logic [2:0]                     mode,
  output scan_res_t                           res,
  output logic      [$clog2(MAX_PROCS)-1:0]   pick
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);

  logic [CNT_W-1:0] nwait_r, nexit_r;
  logic             any_fnd_r, rr_fnd_r, best_fnd_r;
  logic [IDX_W-1:0] any_idx_r, rr_idx_r, best_idx_r;
  logic [31:0]      best_time_r;
  logic             is_ready;
  logic [CNT_W:0]   wait_exit_sum;

  assign is_ready = (st_data == PS_READY);

  // accumulate counts and candidates, one entry per cycle with ctl.dv set
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nwait_r    <= '0;
      nexit_r    <= '0;
      any_fnd_r  <= 1'b0;
      rr_fnd_r   <= 1'b0;
      best_fnd_r <= 1'b0;
    end else if (ctl.clr) begin
      nwait_r    <= '0;
      nexit_r    <= '0;
      any_fnd_r  <= 1'b0;
      rr_fnd_r   <= 1'b0;
      best_fnd_r <= 1'b0;
    end else if (ctl.dv) begin
      if (st_data == PS_WAITING) begin
        nwait_r <= nwait_r + 1'b1;
      end
      if (st_data == PS_EXITING) begin
        nexit_r <= nexit_r + 1'b1;
      end
      // lowest ready index
      if (is_ready && !any_fnd_r) begin
        any_fnd_r <= 1'b1;
        any_idx_r <= idx;
      end
      // lowest ready index at or past the round-robin start
      if (is_ready && !rr_fnd_r && (idx >= rr_start)) begin
        rr_fnd_r <= 1'b1;
        rr_idx_r <= idx;
      end
      // least remaining time, strict compare keeps the lower index on a tie
      if (is_ready && (!best_fnd_r || (tm_data < best_time_r))) begin
        best_fnd_r  <= 1'b1;
        best_idx_r  <= idx;
        best_time_r <= tm_data;
      end
    end
  end

  assign wait_exit_sum = {1'b0, nwait_r} + {1'b0, nexit_r};

  // verdict after the last entry
  always_comb begin
    res.status = STAT_AVAIL;
    res.found  = 1'b0;
    pick       = '0;
    if ((nwait_r != '0) && (wait_exit_sum == {1'b0, n_used})) begin
      res.status = STAT_ALL_WAIT;
    end else if (nexit_r == n_used) begin
      res.status = STAT_ALL_EXIT;
    end else begin
      case (mode) inside
        MODE_FCFS_NP, MODE_FCFS_P: begin
          res.found = any_fnd_r;
          pick      = any_idx_r;
        end
        MODE_RR: begin
          // wrap to the lowest ready entry when none follows the start
          res.found = any_fnd_r;
          pick      = rr_fnd_r ? rr_idx_r : any_idx_r;
        end
        MODE_SJF, MODE_SRTF: begin
          res.found = best_fnd_r;
          pick      = best_idx_r;
        end
        default: begin
          res.found = 1'b0;
        end
      endcase
      if (!res.found) begin
        pick = '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/process_scheduler_select.sv =====
// Process scheduler select.
// Holds a table of MAX_PROCS process entries (state and remaining time) in
// two single-port-write RAMs. Input items use in_valid/in_stall: an update
// item writes one entry, a select item picks the next process by sched_mode
// and marks it running. Each item gives exactly one result on
// out_valid/out_stall (status, chosen_index, chosen_valid).
// Configuration: cfg_valid/cfg_ready write sched_mode (index 0) or num_procs
// (index 1); cfg_ready is always high, write only while idle.
// Sequence: an update or a first-call shortcut goes from the transfer to the
// finishing state and then to the output register; a scanning select first
// reads the n entries in use, one table entry per cycle from the RAM read
// port, then passes the evaluation state. One item is in flight at a time;
// a new item is taken only once the last result is in the output register.
// Reset: table reads back as all zero through per-entry valid bits, no
// clearing pass; sched_mode resets to 0 and num_procs to 1.
// A stalled result is held in the output register; the block finishes the
// next item up to its result and waits there until the output is taken.
`default_nettype none

module process_scheduler_select import psel_pkg::*; #(
  parameter int MAX_PROCS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [3:0]  in_entry_index,
  input  wire logic [2:0]  in_new_state,
  input  wire logic [31:0] in_new_time,
  input  wire logic        in_first_call,
  input  wire logic [3:0]  in_cur_index,
  // results
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [3:0]       out_chosen_index,
  output logic             out_chosen_valid,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data
);

  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

  psel_state_t      state_r, state_nxt;
  logic [2:0]       mode_r;
  logic [4:0]       num_procs_r;
  logic [CNT_W-1:0] n_eff;

  logic             in_xfer;
  logic             upd_ok;
  logic             shortcut;

  // table RAM signals
  logic             st_we, tm_we, rd_en;
  logic [IDX_W-1:0] st_waddr, rd_addr;
  logic [2:0]       st_wdata, st_rdata, st_q;
  logic [31:0]      tm_rdata, tm_q;
  logic [MAX_PROCS-1:0] st_vld_r, tm_vld_r;
  logic             st_vq_r, tm_vq_r;

  // scan sequencing
  logic [CNT_W-1:0] iss_cnt_r, iss_cnt_nxt;
  logic             dv_r, dv_last_r;
  logic [IDX_W-1:0] dv_idx_r;
  logic [IDX_W-1:0] rr_start_r, rr_start_nxt;
  logic [CW-1:0]    cur_plus;
  scan_ctl_t        scan_ctl;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] scan_pick;

  // result and output registers
  logic [1:0]       res_status_r, res_status_nxt;
  logic [IDX_W-1:0] res_idx_r, res_idx_nxt;
  logic             res_vld_r, res_vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_load;
  logic [1:0]       out_status_r;
  logic [3:0]       out_idx_r;
  logic             out_cv_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_FCFS_NP;
      num_procs_r <= 5'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCHED_MODE: mode_r      <= cfg_data[2:0];
        REG_NUM_PROCS:  num_procs_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // entries in use, clamped to 1..MAX_PROCS
  always_comb begin
    if (num_procs_r == 5'd0) begin
      n_eff = CNT_W'(1);
    end else if (32'(num_procs_r) > 32'(MAX_PROCS)) begin
      n_eff = CNT_W'(MAX_PROCS);
    end else begin
      n_eff = CNT_W'(num_procs_r);
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign upd_ok   = (32'(in_entry_index) < 32'(MAX_PROCS));
  assign shortcut = in_first_call &&
                    ((mode_r == MODE_FCFS_NP) || (mode_r == MODE_FCFS_P) ||
                     (mode_r == MODE_RR));
  assign cur_plus = CW'(in_cur_index) + CW'(1);

  // round-robin scan start
  always_comb begin
    if (cur_plus < CW'(n_eff)) begin
      rr_start_nxt = IDX_W'(cur_plus);
    end else begin
      rr_start_nxt = '0;
    end
  end

  // table memories
  psel_ram #(.WIDTH(3), .DEPTH(MAX_PROCS)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  psel_ram #(.WIDTH(32), .DEPTH(MAX_PROCS)) u_time_ram (
    .clk   (clk),
    .we    (tm_we),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (in_new_time),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (tm_rdata)
  );

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_vld_r <= '0;
      tm_vld_r <= '0;
    end else begin
      if (st_we) begin
        st_vld_r[st_waddr] <= 1'b1;
      end
      if (tm_we) begin
        tm_vld_r[IDX_W'(in_entry_index)] <= 1'b1;
      end
    end
  end

  assign rd_addr = iss_cnt_r[IDX_W-1:0];
  assign st_q    = st_vq_r ? st_rdata : PS_NEW;
  assign tm_q    = tm_vq_r ? tm_rdata : 32'd0;

  // read pipeline bookkeeping; all writes come before or after a scan,
  // so no entry is read and written in overlapping cycles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r      <= 1'b0;
      dv_last_r <= 1'b0;
    end else begin
      dv_r      <= rd_en;
      dv_last_r <= rd_en && ((iss_cnt_r + 1'b1) == n_eff);
    end
    dv_idx_r <= rd_addr;
    st_vq_r  <= st_vld_r[rd_addr];
    tm_vq_r  <= tm_vld_r[rd_addr];
  end

  assign scan_ctl.clr = in_xfer && (in_func == FUNC_SELECT) && !shortcut;
  assign scan_ctl.dv  = dv_r;

  psel_scan #(.MAX_PROCS(MAX_PROCS)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (scan_ctl),
    .idx      (dv_idx_r),
    .st_data  (st_q),
    .tm_data  (tm_q),
    .rr_start (rr_start_r),
    .n_used   (n_eff),
    .mode     (mode_r),
    .res      (scan_res),
    .pick     (scan_pick)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      iss_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
    end
    // scan start is held for the whole scan of the accepted item
    if (in_xfer) begin
      rr_start_r <= rr_start_nxt;
    end
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_vld_r    <= res_vld_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= 4'(res_idx_r);
      out_cv_r     <= res_vld_r;
    end
  end

  // next state, RAM writes and result capture
  always_comb begin
    state_nxt      = state_r;
    iss_cnt_nxt    = iss_cnt_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_vld_nxt    = res_vld_r;
    st_we          = 1'b0;
    tm_we          = 1'b0;
    st_waddr       = IDX_W'(in_entry_index);
    st_wdata       = in_new_state;
    rd_en          = 1'b0;
    out_load       = 1'b0;
    out_valid_nxt  = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_func == FUNC_UPDATE) begin
            st_we          = upd_ok;
            tm_we          = upd_ok;
            res_status_nxt = STAT_UPD_ACK;
            res_idx_nxt    = '0;
            res_vld_nxt    = 1'b0;
            state_nxt      = S_DONE;
          end else if (shortcut) begin
            // first call: entry 0 runs, no checks
            st_we          = 1'b1;
            st_waddr       = '0;
            st_wdata       = PS_RUNNING;
            res_status_nxt = STAT_AVAIL;
            res_idx_nxt    = '0;
            res_vld_nxt    = 1'b1;
            state_nxt      = S_DONE;
          end else begin
            iss_cnt_nxt = '0;
            state_nxt   = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (iss_cnt_r != n_eff) begin
          rd_en       = 1'b1;
          iss_cnt_nxt = iss_cnt_r + 1'b1;
        end
        if (dv_r && dv_last_r) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        st_we          = scan_res.found;
        st_waddr       = scan_pick;
        st_wdata       = PS_RUNNING;
        res_status_nxt = scan_res.status;
        res_idx_nxt    = scan_pick;
        res_vld_nxt    = scan_res.found;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_index = out_idx_r;
  assign out_chosen_valid = out_cv_r;

  // a new result only ever comes out of the finishing state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> $past(state_r) == S_EVAL || $past(in_xfer) || $past(state_r) == S_DONE)
    else $error("result loaded outside the finishing path");

  // a selection always reports the available status
  a_chosen_avail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chosen_valid |-> out_status == STAT_AVAIL)
    else $error("chosen entry with a non-available status");

  // the scan never reads past the entries in use
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> iss_cnt_r < n_eff)
    else $error("scan read beyond the used entries");

  // a picked entry lies inside the used range
  a_pick_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EVAL && scan_res.found |-> CNT_W'(scan_pick) < n_eff)
    else $error("picked entry outside the used range");

endmodule

`default_nettype wire
